// ===== rtl/sstf_pkg.sv =====
`default_nettype none

package sstf_pkg;

  // store depth and significant cylinder bits
  localparam int MAX_REQUESTS  = 64;
  localparam int CYLINDER_BITS = 16;

  // fixed field widths
  localparam int CYL_FIELD_W = 16;
  localparam int TOTAL_W     = 22;
  localparam int STATUS_W    = 2;

  // derived widths
  localparam int CYL_W    = (CYLINDER_BITS < CYL_FIELD_W) ? CYLINDER_BITS : CYL_FIELD_W;
  localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);

  // input modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  // one stored request presented to the scan unit
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] idx;
    logic [CYL_W-1:0]    cyl;
  } sstf_entry_t;

  // current best candidate of a scan
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [CYL_W-1:0]    seek;
    logic [CYL_W-1:0]    cyl;
  } sstf_best_t;

endpackage

`default_nettype wire

// ===== rtl/sstf_req_if.sv =====
`default_nettype none

interface sstf_req_if;
  import sstf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [CYL_FIELD_W-1:0] cylinder;

  modport source (output valid, output mode, output cylinder, input ready);
  modport sink   (input valid, input mode, input cylinder, output ready);
endinterface

`default_nettype wire

// ===== rtl/sstf_res_if.sv =====
`default_nettype none

interface sstf_res_if;
  import sstf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CYL_FIELD_W-1:0] served_cylinder;
  logic [CYL_FIELD_W-1:0] seek_distance;
  logic [TOTAL_W-1:0]     total_seek;
  logic                   last;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, output served_cylinder, output seek_distance,
                  output total_seek, output last, output status, input ready);
  modport sink   (input valid, input served_cylinder, input seek_distance,
                  input total_seek, input last, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/sstf_store.sv =====
`default_nettype none

module sstf_store (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [sstf_pkg::IDX_BITS-1:0] wr_addr,
  input  wire logic [sstf_pkg::CYL_W-1:0]    wr_data,
  input  wire logic [sstf_pkg::IDX_BITS-1:0] rd_addr,
  output logic      [sstf_pkg::CYL_W-1:0]    rd_data
);
  import sstf_pkg::*;

  logic [CYL_W-1:0] mem [MAX_REQUESTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/sstf_scan.sv =====
`default_nettype none

module sstf_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire sstf_pkg::sstf_entry_t      entry,
  input  wire logic [sstf_pkg::CYL_W-1:0] head,
  output sstf_pkg::sstf_best_t            best
);
  import sstf_pkg::*;

  logic             found;
  logic [CYL_W-1:0] delta;
  logic             better;

  // absolute distance and nearest-then-lower compare
  always_comb begin
    delta  = (entry.cyl >= head) ? (entry.cyl - head) : (head - entry.cyl);
    better = !found || (delta < best.seek)
             || ((delta == best.seek) && (entry.cyl < best.cyl));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (entry.valid && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clear && entry.valid && better) begin
      best.idx  <= entry.idx;
      best.seek <= delta;
      best.cyl  <= entry.cyl;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sstf_disk_scheduler_top.sv =====
// Shortest-seek-time-first disk scheduler. A load transaction (mode 0) appends
// a cylinder request to a store of MAX_REQUESTS entries; a load into a full
// store is dropped and answered by one result with status dropped. A run
// transaction (mode 1) sets the head and serves every pending request, nearest
// first and lower cylinder first on a tie, emitting one result per service
// with the seek distance and the running total, the final one marked last; an
// empty run gives one result with status empty. Each service walks all n stored
// requests through the single store read port and one distance comparator,
// then hands its result to the output register. The block takes no new
// transaction while a run or a pending result is in progress; the output
// register lets a load be taken while a result still waits downstream. After
// a run the store is empty and the head stays at the last served cylinder.

`default_nettype none

module sstf_disk_scheduler_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sstf_req_if.sink   req,
  sstf_res_if.source res
);
  import sstf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] issue_idx;
  logic [CNT_BITS-1:0] served_cnt;
  logic [CYL_W-1:0]    head;
  logic [TOTAL_W-1:0]  sum;
  logic [MAX_REQUESTS-1:0] flags;

  // read pipeline stage in front of the comparator
  logic                p_vld;
  logic                p_flag;
  logic [IDX_BITS-1:0] p_idx;

  // result waiting for the output register
  logic [CYL_FIELD_W-1:0] pend_cyl;
  logic [CYL_FIELD_W-1:0] pend_dist;
  logic [TOTAL_W-1:0]     pend_total;
  logic                   pend_last;
  logic [STATUS_W-1:0]    pend_status;

  // output register
  logic                   out_vld;
  logic [CYL_FIELD_W-1:0] out_cyl;
  logic [CYL_FIELD_W-1:0] out_dist;
  logic [TOTAL_W-1:0]     out_total;
  logic                   out_last;
  logic [STATUS_W-1:0]    out_status;

  logic             accept;
  logic [CYL_W-1:0] in_cyl;
  logic             store_wr;
  logic [CYL_W-1:0] rd_data;
  logic             out_free;
  logic             scan_clear;
  sstf_entry_t      entry;
  sstf_best_t       best;
  logic [TOTAL_W-1:0] total_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_cyl    = req.cylinder[CYL_W-1:0];
  assign out_free  = !out_vld || res.ready;

  // a load that fits goes straight into the store
  assign store_wr = accept && (req.mode == MODE_LOAD)
                    && (count != CNT_BITS'(MAX_REQUESTS));

  // best candidate restarts on the first cycle of every scan
  assign scan_clear = (state == S_SCAN) && (issue_idx == '0);

  assign entry.valid = p_vld && !p_flag;
  assign entry.idx   = p_idx;
  assign entry.cyl   = rd_data;

  assign total_next = sum + TOTAL_W'(best.seek);

  sstf_store u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count[IDX_BITS-1:0]),
    .wr_data (in_cyl),
    .rd_addr (issue_idx[IDX_BITS-1:0]),
    .rd_data (rd_data)
  );

  sstf_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clear (scan_clear),
    .entry (entry),
    .head  (head),
    .best  (best)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      issue_idx  <= '0;
      served_cnt <= '0;
      head       <= '0;
      sum        <= '0;
      flags      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_LOAD) begin
              if (count == CNT_BITS'(MAX_REQUESTS)) begin
                state <= S_EMIT;
              end else begin
                count <= count + CNT_BITS'(1);
              end
            end else begin
              head       <= in_cyl;
              sum        <= '0;
              served_cnt <= '0;
              issue_idx  <= '0;
              if (count == '0) begin
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (issue_idx != count) begin
            // issue one store read per cycle
            issue_idx <= issue_idx + CNT_BITS'(1);
          end else if (!p_vld) begin
            // last entry compared: commit this service
            sum                          <= total_next;
            head                         <= best.cyl;
            flags[best.idx]              <= 1'b1;
            served_cnt                   <= served_cnt + CNT_BITS'(1);
            state                        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (pend_status == STATUS_DROPPED) begin
              state <= S_IDLE;
            end else if ((pend_status == STATUS_SERVED) && !pend_last) begin
              issue_idx <= '0;
              state     <= S_SCAN;
            end else begin
              // run finished: empty the store
              count <= '0;
              flags <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // read pipeline valid, one store read per scan cycle while reads remain
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= (state == S_SCAN) && (issue_idx != count);
    end
  end

  // output valid: loaded from the pending result, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_SCAN && issue_idx != count) begin
      p_idx  <= issue_idx[IDX_BITS-1:0];
      p_flag <= flags[issue_idx[IDX_BITS-1:0]];
    end

    if (state == S_IDLE && accept) begin
      pend_cyl    <= '0;
      pend_dist   <= '0;
      pend_total  <= '0;
      pend_last   <= (req.mode == MODE_RUN);
      pend_status <= (req.mode == MODE_LOAD) ? STATUS_DROPPED : STATUS_EMPTY;
    end else if (state == S_SCAN && issue_idx == count && !p_vld) begin
      pend_cyl    <= CYL_FIELD_W'(best.cyl);
      pend_dist   <= CYL_FIELD_W'(best.seek);
      pend_total  <= total_next;
      pend_last   <= ((served_cnt + CNT_BITS'(1)) == count);
      pend_status <= STATUS_SERVED;
    end

    if (state == S_EMIT && out_free) begin
      out_cyl    <= pend_cyl;
      out_dist   <= pend_dist;
      out_total  <= pend_total;
      out_last   <= pend_last;
      out_status <= pend_status;
    end
  end

  assign res.valid           = out_vld;
  assign res.served_cylinder = out_cyl;
  assign res.seek_distance   = out_dist;
  assign res.total_seek      = out_total;
  assign res.last            = out_last;
  assign res.status          = out_status;

endmodule

`default_nettype wire
